// ===== rtl/core/accumulator_machine_core_top_defines.svh =====
// Assertion macros shared by the accumulator machine core.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ACCUMULATOR_MACHINE_CORE_TOP_DEFINES_SVH
`define ACCUMULATOR_MACHINE_CORE_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define AMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amc: same-cycle check failed");

// Check cons in the cycle after ante.
`define AMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amc: next-cycle check failed");

`endif

// ===== rtl/core/amc_pkg.sv =====
// Package of the accumulator machine core: sizes, codes, control types.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package amc_pkg;

  localparam int MEM_WORDS = 100;
  localparam int WORD_BITS = 32;
  localparam int IO_BITS   = 32;
  localparam int ADDR_BITS = 7;
  localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int OP_BITS   = 6;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
  localparam logic signed [63:0] END_MARK = -64'sd99999;
  localparam int DEC_BASE  = 100;
  localparam logic [WORD_BITS-1:0] DEC_RECIP = 32'h51EB_851F;
  localparam int DEC_SHIFT = 37;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [3:0] STAT_OK     = 4'd0;
  localparam logic [3:0] STAT_OUT    = 4'd1;
  localparam logic [3:0] STAT_HALT   = 4'd2;
  localparam logic [3:0] STAT_DIV0   = 4'd3;
  localparam logic [3:0] STAT_BADOP  = 4'd4;
  localparam logic [3:0] STAT_BADDBG = 4'd5;
  localparam logic [3:0] STAT_END    = 4'd6;
  localparam logic [3:0] STAT_OVF    = 4'd7;
  localparam logic [3:0] STAT_IDLE   = 4'd8;

  localparam logic [OP_BITS-1:0] OPC_READ   = 6'd10;
  localparam logic [OP_BITS-1:0] OPC_WRITE  = 6'd11;
  localparam logic [OP_BITS-1:0] OPC_LOAD   = 6'd20;
  localparam logic [OP_BITS-1:0] OPC_STORE  = 6'd21;
  localparam logic [OP_BITS-1:0] OPC_ADD    = 6'd30;
  localparam logic [OP_BITS-1:0] OPC_SUB    = 6'd31;
  localparam logic [OP_BITS-1:0] OPC_DIV    = 6'd32;
  localparam logic [OP_BITS-1:0] OPC_MUL    = 6'd33;
  localparam logic [OP_BITS-1:0] OPC_POW    = 6'd34;
  localparam logic [OP_BITS-1:0] OPC_BR     = 6'd40;
  localparam logic [OP_BITS-1:0] OPC_BRNEG  = 6'd41;
  localparam logic [OP_BITS-1:0] OPC_BRZERO = 6'd42;
  localparam logic [OP_BITS-1:0] OPC_HALT   = 6'd43;
  localparam logic [OP_BITS-1:0] OPC_DEBUG  = 6'd44;
  localparam logic [OP_BITS-1:0] OPC_SAT    = 6'd63;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHECK, S_DECODE, S_OPREAD, S_EXEC, S_DIV, S_POW_R, S_POW_B, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    ACC_HOLD, ACC_MEM, ACC_ADD, ACC_SUB, ACC_MUL, ACC_ONE, ACC_ZERO, ACC_DIVQ, ACC_POW
  } acc_op_t;

  typedef enum logic [1:0] {PC_HOLD, PC_ADDR, PC_INC, PC_OPD} pc_op_t;
  typedef enum logic [1:0] {RUN_HOLD, RUN_SET, RUN_CLR} run_op_t;
  typedef enum logic {DIV_DECODE, DIV_ARITH} div_src_t;
  typedef enum logic {RD_PC, RD_OPD} rd_sel_t;
  typedef enum logic {WD_WORD, WD_ACC} wr_data_t;
  typedef enum logic {WA_IN, WA_OPD} wr_addr_t;

  typedef struct packed {
    logic     latch_in;
    logic     set_status;
    logic [3:0] status_code;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     mem_wr;
    wr_data_t wr_data;
    wr_addr_t wr_addr;
    acc_op_t  acc_op;
    pc_op_t   pc_op;
    run_op_t  run_op;
    logic     div_start;
    div_src_t div_src;
    logic     div_step;
    logic     dec_load;
    logic     outv_load;
    logic     pow_init;
    logic     pow_r_step;
    logic     pow_b_step;
    logic     out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               running;
    logic               pc_ok;
    logic               addr_ok;
    logic               iw_end;
    logic               iw_neg;
    logic               div_done;
    logic [OP_BITS-1:0] op;
    logic               acc_zero;
    logic               acc_one;
    logic               acc_neg;
    logic               m_zero;
    logic               dbg_bad;
    logic               exp_zero;
    logic               pow_neg;
    logic               p_zero;
  } dp_stat_t;

  function automatic logic [WORD_BITS-1:0] to_word(input logic [IO_BITS-1:0] v);
    logic signed [WORD_BITS+IO_BITS-1:0] t;
    t = signed'(v);
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic [IO_BITS-1:0] from_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS+IO_BITS-1:0] t;
    t = {{IO_BITS{1'b0}}, v};
    return t[IO_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/amc_datapath.sv =====
// Datapath of the accumulator machine core: memory, registers, divider,
// multiplier and power loop. Depends on amc_pkg; driven by amc_controller.
`timescale 1ns / 1ps

module amc_datapath import amc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_ctl_t               ctl,
  output dp_stat_t              stat,
  input  logic [1:0]            cmd,
  input  logic [ADDR_BITS-1:0]  address,
  input  logic [IO_BITS-1:0]    word,
  output logic [3:0]            status,
  output logic [IO_BITS-1:0]    out_value,
  output logic [IO_BITS-1:0]    acc_now,
  output logic [ADDR_BITS-1:0]  pc_now
);

  localparam int WB = WORD_BITS;

  logic [WB-1:0]        mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_valid;

  logic [1:0]           cmd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [WB-1:0]        word_q;
  logic [WB-1:0]        acc;
  logic [ADDR_BITS-1:0] pc;
  logic                 running;
  logic [3:0]           stat_q;
  logic [WB-1:0]        outv;
  logic [WB-1:0]        rdata;
  logic [OP_BITS-1:0]   op_q;
  logic [ADDR_BITS-1:0] opd_q;

  logic [WB-1:0]        dv_q;
  logic [WB-1:0]        dv_rem;
  logic [WB-1:0]        dv_den;
  logic [CNT_BITS-1:0]  dv_cnt;
  logic                 dv_neg;

  logic [WB-1:0]        pw_r;
  logic [WB-1:0]        pw_b;
  logic [WB-1:0]        pw_e;
  logic                 pw_neg;

  logic [ADDR_BITS-1:0] rd_addr;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [WB-1:0]        wr_data;
  logic [WB-1:0]        mul_a;
  logic [WB-1:0]        mul_b;
  logic [2*WB-1:0]      mul_full;
  logic [2*WB-1:0]      dec_full;
  logic [ADDR_BITS-1:0] dec_opd;
  logic [WB:0]          dv_sh;
  logic                 dv_ge;
  logic [WB-1:0]        dv_res;
  logic [WB-1:0]        pw_inv;
  logic [WB-1:0]        pw_res;
  logic [WB-1:0]        m_abs;
  logic [WB-1:0]        acc_abs;
  logic signed [63:0]   rd_sx;

  assign rd_addr = (ctl.rd_sel == RD_PC) ? pc : opd_q;
  assign wr_addr = (ctl.wr_addr == WA_IN) ? addr_q : opd_q;
  assign wr_data = (ctl.wr_data == WD_WORD) ? word_q : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
    end else if (ctl.mem_wr && (wr_addr < ADDR_BITS'(MEM_WORDS))) begin
      mem_valid[wr_addr[MEM_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_wr && (wr_addr < ADDR_BITS'(MEM_WORDS))) begin
      mem[wr_addr[MEM_AW-1:0]] <= wr_data;
    end
    if (ctl.rd_en) begin
      if ((rd_addr < ADDR_BITS'(MEM_WORDS)) && mem_valid[rd_addr[MEM_AW-1:0]]) begin
        rdata <= mem[rd_addr[MEM_AW-1:0]];
      end else begin
        rdata <= '0;
      end
    end
  end

  assign mul_a    = ctl.pow_b_step ? pw_b : (ctl.pow_r_step ? pw_r : acc);
  assign mul_b    = (ctl.pow_b_step || ctl.pow_r_step) ? pw_b : rdata;
  assign mul_full = mul_a * mul_b;

  assign dec_full = (2*WB)'(rdata) * (2*WB)'(DEC_RECIP);
  assign dec_opd  = rdata[ADDR_BITS-1:0] -
                    ADDR_BITS'(dv_q[ADDR_BITS-1:0] * ADDR_BITS'(DEC_BASE));

  assign dv_sh  = {dv_rem, dv_q[WB-1]};
  assign dv_ge  = dv_sh >= {1'b0, dv_den};
  assign dv_res = dv_neg ? (~dv_q + WB'(1)) : dv_q;

  assign m_abs   = rdata[WB-1] ? (~rdata + WB'(1)) : rdata;
  assign acc_abs = acc[WB-1] ? (~acc + WB'(1)) : acc;

  assign pw_inv = (pw_r == WB'(1)) ? WB'(1) : ((pw_r == '1) ? '1 : '0);
  assign pw_res = pw_neg ? pw_inv : pw_r;

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      dv_rem <= '0;
      if (ctl.div_src == DIV_DECODE) begin
        dv_cnt <= CNT_BITS'(WB);
        dv_q   <= WB'(dec_full >> DEC_SHIFT);
        dv_den <= WB'(DEC_BASE);
        dv_neg <= 1'b0;
      end else begin
        dv_cnt <= '0;
        dv_q   <= m_abs;
        dv_den <= acc_abs;
        dv_neg <= rdata[WB-1] ^ acc[WB-1];
      end
    end else if (ctl.div_step && (dv_cnt != CNT_BITS'(WB))) begin
      dv_cnt <= dv_cnt + CNT_BITS'(1);
      dv_rem <= dv_ge ? WB'(dv_sh - {1'b0, dv_den}) : dv_sh[WB-1:0];
      dv_q   <= {dv_q[WB-2:0], dv_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dec_load) begin
      op_q  <= (dv_q > WB'(OPC_SAT)) ? OPC_SAT : dv_q[OP_BITS-1:0];
      opd_q <= dec_opd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pow_init) begin
      pw_r   <= WB'(1);
      pw_b   <= acc;
      pw_e   <= m_abs;
      pw_neg <= rdata[WB-1];
    end else if (ctl.pow_r_step) begin
      if (pw_e[0]) begin
        pw_r <= mul_full[WB-1:0];
      end
    end else if (ctl.pow_b_step) begin
      pw_b <= mul_full[WB-1:0];
      pw_e <= pw_e >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pc      <= '0;
      running <= 1'b0;
    end else begin
      case (ctl.acc_op)
        ACC_MEM:  acc <= rdata;
        ACC_ADD:  acc <= acc + rdata;
        ACC_SUB:  acc <= acc - rdata;
        ACC_MUL:  acc <= mul_full[WB-1:0];
        ACC_ONE:  acc <= WB'(1);
        ACC_ZERO: acc <= '0;
        ACC_DIVQ: acc <= dv_res;
        ACC_POW:  acc <= pw_res;
        default:  acc <= acc;
      endcase
      case (ctl.pc_op)
        PC_ADDR: pc <= addr_q;
        PC_INC:  pc <= pc + ADDR_BITS'(1);
        PC_OPD:  pc <= opd_q;
        default: pc <= pc;
      endcase
      case (ctl.run_op)
        RUN_SET: running <= 1'b1;
        RUN_CLR: running <= 1'b0;
        default: running <= running;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_q  <= cmd;
      addr_q <= address;
      word_q <= to_word(word);
      stat_q <= STAT_OK;
      outv   <= '0;
    end else begin
      if (ctl.set_status) begin
        stat_q <= ctl.status_code;
      end
      if (ctl.outv_load) begin
        outv <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status    <= stat_q;
      out_value <= from_word(outv);
      acc_now   <= from_word(acc);
      pc_now    <= pc;
    end
  end

  assign rd_sx = 64'(signed'(rdata));

  always_comb begin
    stat.cmd      = cmd_q;
    stat.running  = running;
    stat.pc_ok    = pc < ADDR_BITS'(MEM_WORDS);
    stat.addr_ok  = addr_q < ADDR_BITS'(MEM_WORDS);
    stat.iw_end   = rd_sx == END_MARK;
    stat.iw_neg   = rdata[WB-1];
    stat.div_done = dv_cnt == CNT_BITS'(WB);
    stat.op       = op_q;
    stat.acc_zero = acc == '0;
    stat.acc_one  = acc == WB'(1);
    stat.acc_neg  = acc[WB-1];
    stat.m_zero   = rdata == '0;
    stat.dbg_bad  = opd_q > ADDR_BITS'(1);
    stat.exp_zero = pw_e == '0;
    stat.pow_neg  = pw_neg;
    stat.p_zero   = pw_r == '0;
  end

endmodule

// ===== rtl/core/amc_controller.sv =====
// Controller of the accumulator machine core: sequences each word through
// the datapath and runs both handshakes. Depends on amc_pkg and the defines.
`timescale 1ns / 1ps
`include "accumulator_machine_core_top_defines.svh"

module amc_controller import amc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FIN;
        case (stat.cmd)
          CMD_LOAD: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_data = WD_WORD;
            ctl.wr_addr = WA_IN;
          end
          CMD_START: begin
            if (stat.addr_ok) begin
              ctl.pc_op  = PC_ADDR;
              ctl.run_op = RUN_SET;
            end else begin
              ctl.run_op      = RUN_CLR;
              ctl.set_status  = 1'b1;
              ctl.status_code = STAT_OVF;
            end
          end
          CMD_STEP: begin
            if (!stat.running) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = STAT_IDLE;
            end else if (!stat.pc_ok) begin
              ctl.run_op      = RUN_CLR;
              ctl.set_status  = 1'b1;
              ctl.status_code = STAT_OVF;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_PC;
              state_next = S_CHECK;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_CHECK: begin
        if (stat.iw_end) begin
          ctl.run_op      = RUN_CLR;
          ctl.set_status  = 1'b1;
          ctl.status_code = STAT_END;
          state_next      = S_FIN;
        end else if (stat.iw_neg) begin
          ctl.pc_op       = PC_INC;
          ctl.set_status  = 1'b1;
          ctl.status_code = STAT_BADOP;
          state_next      = S_FIN;
        end else begin
          ctl.div_start = 1'b1;
          ctl.div_src   = DIV_DECODE;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.div_done) begin
          ctl.dec_load = 1'b1;
          state_next   = S_OPREAD;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      S_OPREAD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_OPD;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_FIN;
        ctl.pc_op  = PC_INC;
        case (stat.op)
          OPC_READ: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_data = WD_WORD;
            ctl.wr_addr = WA_OPD;
          end
          OPC_WRITE: begin
            ctl.outv_load   = 1'b1;
            ctl.set_status  = 1'b1;
            ctl.status_code = STAT_OUT;
          end
          OPC_LOAD:  ctl.acc_op = ACC_MEM;
          OPC_STORE: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_data = WD_ACC;
            ctl.wr_addr = WA_OPD;
          end
          OPC_ADD: ctl.acc_op = ACC_ADD;
          OPC_SUB: ctl.acc_op = ACC_SUB;
          OPC_MUL: ctl.acc_op = ACC_MUL;
          OPC_DIV: begin
            if (stat.acc_zero) begin
              ctl.run_op      = RUN_CLR;
              ctl.set_status  = 1'b1;
              ctl.status_code = STAT_DIV0;
            end else begin
              ctl.div_start = 1'b1;
              ctl.div_src   = DIV_ARITH;
              state_next    = S_DIV;
            end
          end
          OPC_POW: begin
            if (stat.acc_one) begin
              ctl.acc_op = ACC_HOLD;
            end else if (stat.m_zero) begin
              ctl.acc_op = ACC_ONE;
            end else begin
              ctl.pow_init = 1'b1;
              state_next   = S_POW_R;
            end
          end
          OPC_BR: ctl.pc_op = PC_OPD;
          OPC_BRNEG: begin
            if (stat.acc_neg) begin
              ctl.pc_op = PC_OPD;
            end
          end
          OPC_BRZERO: begin
            if (stat.acc_zero) begin
              ctl.pc_op = PC_OPD;
            end
          end
          OPC_HALT: begin
            ctl.acc_op      = ACC_ZERO;
            ctl.run_op      = RUN_CLR;
            ctl.set_status  = 1'b1;
            ctl.status_code = STAT_HALT;
          end
          OPC_DEBUG: begin
            if (stat.dbg_bad) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = STAT_BADDBG;
            end
          end
          default: begin
            ctl.set_status  = 1'b1;
            ctl.status_code = STAT_BADOP;
          end
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          ctl.acc_op = ACC_DIVQ;
          state_next = S_FIN;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      S_POW_R: begin
        if (stat.exp_zero) begin
          state_next = S_FIN;
          if (stat.pow_neg && stat.p_zero) begin
            ctl.run_op      = RUN_CLR;
            ctl.set_status  = 1'b1;
            ctl.status_code = STAT_DIV0;
          end else begin
            ctl.acc_op = ACC_POW;
          end
        end else begin
          ctl.pow_r_step = 1'b1;
          state_next     = S_POW_B;
        end
      end
      S_POW_B: begin
        ctl.pow_b_step = 1'b1;
        state_next     = S_POW_R;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `AMC_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state == S_DISPATCH)
  `AMC_ASSERT_NEXT(a_decode_to_opread, state == S_DECODE && stat.div_done, state == S_OPREAD)
  `AMC_ASSERT_NEXT(a_fin_delivers, state == S_FIN && !out_valid, out_valid && state == S_IDLE)
  `AMC_ASSERT_NOW(a_no_rd_wr_clash, ctl.mem_wr, !ctl.rd_en)

endmodule

// ===== rtl/core/accumulator_machine_core_top.sv =====
// Top level of the accumulator machine core.
// Depends on amc_pkg, amc_controller and amc_datapath.
//
// Input channel (in_valid/in_ready) takes one word: cmd, address, word.
// cmd 0 loads word into memory, 1 starts at address, 2 executes one
// instruction (word is the value a read instruction takes).
// Output channel (out_valid/out_ready) returns one word per input word:
// status, out_value, acc_now, pc_now.
// Sequence: load and start go from accept through dispatch to the output
// register. An executed instruction goes through fetch, split of the
// fetched word into opcode and operand by a reciprocal multiply, operand
// read and execute. An end marker or a negative word finishes at the check
// of the fetched word. Divide adds a run of the serial divider; power adds
// a result and a base multiply per exponent bit on the shared multiplier.
// One word is worked at a time; in_ready rises the cycle after output load.
// Reset clears accumulator, program counter, running flag and the
// per-entry valid bits, so memory reads as zero at once.
// When the receiver stalls, the finished word holds in the output register
// and the next input word is still accepted and worked; it waits for the
// output register before it completes.

`timescale 1ns / 1ps

module accumulator_machine_core_top import amc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [IO_BITS-1:0]   word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           status,
  output logic [IO_BITS-1:0]   out_value,
  output logic [IO_BITS-1:0]   acc_now,
  output logic [ADDR_BITS-1:0] pc_now
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  amc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  amc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cmd       (cmd),
    .address   (address),
    .word      (word),
    .status    (status),
    .out_value (out_value),
    .acc_now   (acc_now),
    .pc_now    (pc_now)
  );

endmodule

// ===== sim/tb.sv =====
// Testbench for accumulator_machine_core_top: directed programs, then random
// programs and noise under varied handshake idling, checked by an in-bench model.
// Depends on amc_pkg and the RTL of the accumulator machine core.
`timescale 1ns / 1ps

module tb;
  import amc_pkg::*;

  typedef struct {
    logic [3:0]  st;
    logic [31:0] outv;
    logic [31:0] acc;
    logic [6:0]  pc;
  } machine_result_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [1:0]           cmd = 0;
  logic [ADDR_BITS-1:0] address = 0;
  logic [IO_BITS-1:0]   word = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [3:0]           status;
  logic [IO_BITS-1:0]   out_value;
  logic [IO_BITS-1:0]   acc_now;
  logic [ADDR_BITS-1:0] pc_now;

  accumulator_machine_core_top uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [31:0]     sim_mem [MEM_WORDS];
  logic [31:0]     sim_acc = 0;
  logic [6:0]      sim_pc = 0;
  logic            sim_running = 0;
  machine_result_t pending_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int words_checked = 0;
  int mismatches = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  logic [5:0] op_list [14] = '{OPC_READ, OPC_WRITE, OPC_LOAD, OPC_STORE, OPC_ADD, OPC_SUB,
    OPC_DIV, OPC_MUL, OPC_POW, OPC_BR, OPC_BRNEG, OPC_BRZERO, OPC_HALT, OPC_DEBUG};

  function automatic logic [31:0] sdiv32(logic [31:0] num, logic [31:0] den);
    logic [31:0] an, ad, q;
    an = num[31] ? -num : num;
    ad = den[31] ? -den : den;
    q = an / ad;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] wrap_pow(logic [31:0] b, logic [31:0] n);
    logic [31:0] r;
    r = 1;
    for (int i = 0; i < 32; i++) begin
      if (n[i]) r = r * b;
      b = b * b;
    end
    return r;
  endfunction

  function automatic machine_result_t predict_machine(logic [1:0] c, logic [6:0] a,
                                                       logic [31:0] w);
    machine_result_t r;
    logic signed [31:0] sw;
    logic [31:0] m, acc, p;
    logic [6:0] nxt;
    int op, opd;
    r.st = STAT_OK;
    r.outv = 0;
    if (c == CMD_LOAD) begin
      if (a < MEM_WORDS) sim_mem[a] = w;
    end else if (c == CMD_START) begin
      if (a < MEM_WORDS) begin
        sim_pc = a;
        sim_running = 1;
      end else begin
        sim_running = 0;
        r.st = STAT_OVF;
      end
    end else if (c == CMD_STEP) begin
      if (!sim_running) begin
        r.st = STAT_IDLE;
      end else if (sim_pc >= MEM_WORDS) begin
        sim_running = 0;
        r.st = STAT_OVF;
      end else begin
        sw = sim_mem[sim_pc];
        nxt = 7'(sim_pc + 7'd1);
        if (sw == -99999) begin
          sim_running = 0;
          r.st = STAT_END;
        end else begin
          acc = sim_acc;
          if (sw >= 0) begin
            op = sw / 100;
            opd = sw % 100;
          end else begin
            op = 1000;
            opd = 0;
          end
          m = sim_mem[opd];
          case (op)
            OPC_READ: sim_mem[opd] = w;
            OPC_WRITE: begin
              r.outv = m;
              r.st = STAT_OUT;
            end
            OPC_LOAD: acc = m;
            OPC_STORE: sim_mem[opd] = acc;
            OPC_ADD: acc = acc + m;
            OPC_SUB: acc = acc - m;
            OPC_DIV: begin
              if (acc == 0) begin
                sim_running = 0;
                r.st = STAT_DIV0;
              end else begin
                acc = sdiv32(m, acc);
              end
            end
            OPC_MUL: acc = acc * m;
            OPC_POW: begin
              if (acc == 1) begin
              end else if (m == 0) begin
                acc = 1;
              end else if (!m[31]) begin
                acc = wrap_pow(acc, m);
              end else begin
                p = wrap_pow(acc, -m);
                if (p == 0) begin
                  sim_running = 0;
                  r.st = STAT_DIV0;
                end else begin
                  acc = sdiv32(1, p);
                end
              end
            end
            OPC_BR: nxt = 7'(opd);
            OPC_BRNEG: if (acc[31]) nxt = 7'(opd);
            OPC_BRZERO: if (acc == 0) nxt = 7'(opd);
            OPC_HALT: begin
              acc = 0;
              sim_running = 0;
              r.st = STAT_HALT;
            end
            OPC_DEBUG: if (opd > 1) r.st = STAT_BADDBG;
            default: r.st = STAT_BADOP;
          endcase
          sim_acc = acc;
          sim_pc = nxt;
        end
      end
    end
    r.acc = sim_acc;
    r.pc = sim_pc;
    return r;
  endfunction

  task automatic send_word(logic [1:0] c, logic [6:0] a, logic [31:0] w);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    address <= a;
    word <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_machine(c, a, w));
    words_sent++;
  endtask

  always @(posedge clk) begin
    machine_result_t e;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word status=%0d", status);
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st || out_value !== e.outv || acc_now !== e.acc || pc_now !== e.pc)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d out=%0d acc=%0d pc=%0d, got st=%0d out=%0d acc=%0d pc=%0d",
                     e.st, $signed(e.outv), $signed(e.acc), e.pc,
                     status, $signed(out_value), $signed(acc_now), pc_now);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 300;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 9);
      6: return -$urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_instr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 84) return op_list[$urandom_range(0, 13)] * 100 + $urandom_range(0, 99);
    if (r < 89) return -99999;
    if (r < 93) return 32'h8000_0000 | $urandom;
    if (r < 96) return OPC_DEBUG * 100 + $urandom_range(0, 3);
    return $urandom_range(0, 9999);
  endfunction

  task automatic run_program();
    int base, len;
    base = $urandom_range(0, 70);
    len = $urandom_range(3, 12);
    for (int i = 0; i < len; i++) send_word(CMD_LOAD, 7'(base + i), rand_instr());
    repeat ($urandom_range(1, 5)) send_word(CMD_LOAD, 7'($urandom_range(0, 99)), rand_data());
    send_word(CMD_START, 7'(base), $urandom);
    repeat ($urandom_range(4, 20)) send_word(CMD_STEP, 7'($urandom_range(0, 127)), rand_data());
  endtask

  task automatic test_directed();
    send_word(CMD_STEP, 0, 0);
    send_word(CMD_UNUSED, 5, 32'h1234_5678);
    send_word(CMD_LOAD, 127, 32'hFFFF_FFFF);
    send_word(CMD_START, 100, 0);
    send_word(CMD_LOAD, 99, OPC_DEBUG * 100);
    send_word(CMD_START, 99, 0);
    send_word(CMD_STEP, 0, 0);
    send_word(CMD_STEP, 0, 0);
    send_word(CMD_LOAD, 0, -99999);
    send_word(CMD_START, 0, 0);
    send_word(CMD_STEP, 0, 0);
    send_word(CMD_LOAD, 0, OPC_LOAD * 100 + 98);
    send_word(CMD_LOAD, 98, 32'hFFFF_FFFF);
    send_word(CMD_LOAD, 1, OPC_DIV * 100 + 97);
    send_word(CMD_LOAD, 97, 32'h8000_0000);
    send_word(CMD_LOAD, 2, OPC_POW * 100 + 96);
    send_word(CMD_LOAD, 96, -2);
    send_word(CMD_START, 0, 0);
    repeat (3) send_word(CMD_STEP, 0, 0);
    send_word(CMD_LOAD, 3, 32'h8000_0000);
    send_word(CMD_LOAD, 4, 1250);
    send_word(CMD_START, 3, 0);
    repeat (2) send_word(CMD_STEP, 0, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(int idle, int stall, int count);
    int stop;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop = words_sent + count;
    while (words_sent < stop) begin
      if ($urandom_range(0, 9) == 0)
        send_word(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom);
      else
        run_program();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req <= hold_req + 1;
    run_program();
    run_program();
  endtask

  initial begin
    foreach (sim_mem[i]) sim_mem[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(0, 0, 200);
    test_random(48, 0, 200);
    test_random(0, 48, 200);
    test_random(31, 31, 200);
    test_backpressure();
    @(posedge clk);
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d words (%0d results) of load, start, step and noise", words_sent,
             words_checked);
    $display("idling phases none/sender/receiver/both plus one long receiver hold");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
